/* hdl/lslc_pkg.sv */
// lslc_pkg: widths, register indexes and breakpoint tables of the lux calculation
// used by light_sensor_lux_calculation; depends on nothing
`timescale 1ns / 1ps

package lslc_pkg;

	localparam int RAW_W    = 16;
	localparam int FAC_W    = 19;
	localparam int SCALE_SH = 10;
	localparam int CH_W     = 25;
	localparam int DIVD_W   = CH_W + SCALE_SH;
	localparam int QB       = 11;
	localparam int RATIO_W  = 11;
	localparam int COEF_W   = 10;
	localparam int PROD_W   = CH_W + COEF_W;
	localparam int LUX_W    = 20;
	localparam int LUX_SH   = 14;
	localparam int NSEG     = 7;

	localparam logic [1:0] CFG_GAIN  = 2'd0;
	localparam logic [1:0] CFG_ITIME = 2'd1;
	localparam logic [1:0] CFG_PKG   = 2'd2;

	localparam logic [1:0] ITIME_13MS  = 2'd0;
	localparam logic [1:0] ITIME_101MS = 2'd1;

	localparam logic [FAC_W-1:0] FAC_13MS    = FAC_W'(16'h7517);
	localparam logic [FAC_W-1:0] FAC_101MS   = FAC_W'(16'h0FE7);
	localparam logic [FAC_W-1:0] FAC_NOMINAL = FAC_W'(1) << SCALE_SH;

	localparam logic [RATIO_W-1:0] RATIO_OVER = '1;
	localparam logic [LUX_W-1:0]   LUX_MAX    = '1;

	typedef struct packed {
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] m;
	} seg_t;

	typedef logic [RATIO_W-1:0] lim_arr_t [NSEG];
	typedef logic [COEF_W-1:0]  coef_arr_t [NSEG];

	localparam lim_arr_t LIM_T = '{11'h040, 11'h080, 11'h0c0, 11'h100,
		11'h138, 11'h19a, 11'h29a};
	localparam coef_arr_t B_T = '{10'h1f2, 10'h214, 10'h23f, 10'h270,
		10'h16f, 10'h0d2, 10'h018};
	localparam coef_arr_t M_T = '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe,
		10'h1fc, 10'h0fb, 10'h012};
	localparam lim_arr_t LIM_CS = '{11'h043, 11'h085, 11'h0c8, 11'h10a,
		11'h14d, 11'h19a, 11'h29a};
	localparam coef_arr_t B_CS = '{10'h204, 10'h228, 10'h253, 10'h282,
		10'h177, 10'h101, 10'h037};
	localparam coef_arr_t M_CS = '{10'h1ad, 10'h2c1, 10'h363, 10'h3df,
		10'h1dd, 10'h127, 10'h02b};

	// first segment whose limit is not below the ratio; past the last one b = m = 0
	function automatic seg_t seg_lookup(input logic cs, input logic [RATIO_W-1:0] ratio);
		seg_t r;
		r = '0;
		for (int i = NSEG - 1; i >= 0; i--) begin
			if (cs) begin
				if (ratio <= LIM_CS[i]) begin
					r.b = B_CS[i];
					r.m = M_CS[i];
				end
			end else begin
				if (ratio <= LIM_T[i]) begin
					r.b = B_T[i];
					r.m = M_T[i];
				end
			end
		end
		return r;
	endfunction

endpackage

/* hdl/light_sensor_lux_calculation.sv */
// light_sensor_lux_calculation: pipelined two-channel lux calculation
// depends on lslc_pkg (widths, register indexes, breakpoint tables)
`timescale 1ns / 1ps

// Usage
//   input channel: in_valid / in_ready with broadband_count and infrared_count,
//   one pair per item; output channel: out_valid / out_ready with lux, one
//   result per item, in order.
//   configuration: cfg_we with cfg_index and cfg_data, registered on the clock;
//   index 0 gain_sixteen, 1 integration_time, 2 package_type. Write only while
//   the pipeline is empty.
//   pipeline: 16 stages. Stage 1 scales both counts, stage 2 sets up the
//   divide, stages 3 to 13 form the ratio one quotient bit per stage,
//   stage 14 rounds and picks the segment, stage 15 multiplies, stage 16
//   subtracts, rounds and saturates into the output register.
//   throughput: one item per cycle while in_ready is high; the quotient
//   pipeline sets the depth.
//   stall: a stage holds while it and every stage after it are full and
//   out_ready is low, so bubbles are squeezed out and in_ready drops only
//   when all 16 stages are full.
//   reset: arst_n clears all valid bits and loads gain_sixteen 0,
//   integration_time 2 and package_type 0.
module light_sensor_lux_calculation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lslc_pkg::RAW_W-1:0] broadband_count,
	input  logic [lslc_pkg::RAW_W-1:0] infrared_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lslc_pkg::LUX_W-1:0] lux,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [1:0]                 cfg_data
);
	import lslc_pkg::*;

	localparam int ST_DIV0 = 2;
	localparam int ST_SEG  = ST_DIV0 + QB + 1;
	localparam int ST_MUL  = ST_SEG + 1;
	localparam int NS      = ST_MUL + 1;

	// configuration
	logic       gain_q;
	logic [1:0] itime_q;
	logic       pkg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 1'b0;
			itime_q <= 2'd2;
			pkg_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN:  gain_q  <= cfg_data[0];
				CFG_ITIME: itime_q <= cfg_data;
				CFG_PKG:   pkg_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits and stage enables
	logic [NS:1] vld_s;
	logic [NS:1] en;

	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = out_ready | ~(&vld_s[NS:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready = en[1];

	// stage 1: integration and gain scaling
	logic [FAC_W-1:0]        factor;
	logic [FAC_W-1:0]        factor_base;
	logic [RAW_W+FAC_W-1:0]  prod0_raw, prod1_raw;
	logic [CH_W-1:0]         ch0_s1, ch1_s1;

	always_comb begin
		case (itime_q)
			ITIME_13MS:  factor_base = FAC_13MS;
			ITIME_101MS: factor_base = FAC_101MS;
			default:     factor_base = FAC_NOMINAL;
		endcase
		factor = gain_q ? factor_base : (factor_base << 4);
	end

	assign prod0_raw = (RAW_W+FAC_W)'(broadband_count) * (RAW_W+FAC_W)'(factor);
	assign prod1_raw = (RAW_W+FAC_W)'(infrared_count) * (RAW_W+FAC_W)'(factor);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ch0_s1 <= prod0_raw[RAW_W+FAC_W-1:SCALE_SH];
			ch1_s1 <= prod1_raw[RAW_W+FAC_W-1:SCALE_SH];
		end
	end

	// stage 2 (index 0) and stages 3 to 13 (index 1 to QB): restoring divide
	logic [DIVD_W-1:0] div_rem_s [QB+1];
	logic [CH_W-1:0]   div_dsr_s [QB+1];
	logic [CH_W-1:0]   div_ch1_s [QB+1];
	logic [QB-1:0]     div_q_s   [QB+1];
	logic              div_zero_s [QB+1];
	logic              div_ovf_s  [QB+1];

	always_ff @(posedge clk) begin
		if (en[ST_DIV0]) begin
			div_rem_s[0]  <= {ch1_s1, SCALE_SH'(0)};
			div_dsr_s[0]  <= ch0_s1;
			div_ch1_s[0]  <= ch1_s1;
			div_q_s[0]    <= '0;
			div_zero_s[0] <= (ch0_s1 == '0);
			// quotient would need more than QB bits
			div_ovf_s[0]  <= ({1'b0, ch1_s1} >= {ch0_s1, 1'b0});
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int SH = QB - j;
		logic [DIVD_W-1:0] trial;
		logic              take;

		assign trial = DIVD_W'(div_dsr_s[j-1]) << SH;
		assign take  = (div_rem_s[j-1] >= trial);

		always_ff @(posedge clk) begin
			if (en[ST_DIV0+j]) begin
				div_rem_s[j]  <= take ? (div_rem_s[j-1] - trial) : div_rem_s[j-1];
				div_q_s[j]    <= div_q_s[j-1] | (take ? (QB'(1) << SH) : '0);
				div_dsr_s[j]  <= div_dsr_s[j-1];
				div_ch1_s[j]  <= div_ch1_s[j-1];
				div_zero_s[j] <= div_zero_s[j-1];
				div_ovf_s[j]  <= div_ovf_s[j-1];
			end
		end
	end

	// stage 14: round the ratio and pick the segment
	logic [QB:0]        q_inc;
	logic [RATIO_W-1:0] ratio;
	seg_t               seg;
	logic [COEF_W-1:0]  b_s14, m_s14;
	logic [CH_W-1:0]    ch0_s14, ch1_s14;

	always_comb begin
		q_inc = {1'b0, div_q_s[QB]} + (QB+1)'(1);
		if (div_zero_s[QB]) begin
			ratio = '0;
		end else if (div_ovf_s[QB]) begin
			ratio = RATIO_OVER;
		end else begin
			ratio = RATIO_W'(q_inc[QB:1]);
		end
		seg = seg_lookup(pkg_q, ratio);
	end

	always_ff @(posedge clk) begin
		if (en[ST_SEG]) begin
			b_s14   <= seg.b;
			m_s14   <= seg.m;
			ch0_s14 <= div_dsr_s[QB];
			ch1_s14 <= div_ch1_s[QB];
		end
	end

	// stage 15: segment products
	logic [PROD_W-1:0] prod0_s15, prod1_s15;

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			prod0_s15 <= PROD_W'(ch0_s14) * PROD_W'(b_s14);
			prod1_s15 <= PROD_W'(ch1_s14) * PROD_W'(m_s14);
		end
	end

	// stage 16: clamp at zero, round, saturate
	logic [PROD_W-1:0]       diff;
	logic [PROD_W:0]         lux_sum;
	logic [PROD_W-LUX_SH:0]  lux_full;
	logic [LUX_W-1:0]        lux_s16;

	always_comb begin
		diff     = (prod0_s15 > prod1_s15) ? (prod0_s15 - prod1_s15) : '0;
		lux_sum  = {1'b0, diff} + ((PROD_W+1)'(1) << (LUX_SH - 1));
		lux_full = lux_sum[PROD_W:LUX_SH];
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			lux_s16 <= (|lux_full[PROD_W-LUX_SH:LUX_W]) ? LUX_MAX : lux_full[LUX_W-1:0];
		end
	end

	assign out_valid = vld_s[NS];
	assign lux       = lux_s16;

`ifndef SYNTHESIS
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> ((&vld_s) && !out_ready))
		else $error("input stalled while the pipeline has room");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_SEG-1] && !div_zero_s[QB] && !div_ovf_s[QB])
		|-> (div_rem_s[QB] < DIVD_W'(div_dsr_s[QB])))
		else $error("divider remainder not below divisor");

	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_SEG] && !en[ST_MUL]) |=> (vld_s[ST_SEG] && $stable(b_s14)
		&& $stable(m_s14) && $stable(ch0_s14)))
		else $error("stalled segment stage changed");
`endif

endmodule
